// ===== rtl/mots_pkg.sv =====
`timescale 1ns / 1ps
// mots_pkg: shared constants for the median-of-two-sorted-lists block.
// No dependencies.
package mots_pkg;
    localparam int MAX_LEN = 1024;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
endpackage

// ===== rtl/mots_if.sv =====
`timescale 1ns / 1ps
// mots_in_if / mots_out_if: valid/ready channels for list pairs and results.
// Depends on mots_pkg.
interface mots_in_if;
    import mots_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] a_value;
    logic signed [DATA_W-1:0] b_value;
    logic                     last;
    modport source (output valid, a_value, b_value, last, input ready);
    modport sink   (input valid, a_value, b_value, last, output ready);
endinterface

interface mots_out_if;
    import mots_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] median;
    logic                     overflow;
    modport source (output valid, median, overflow, input ready);
    modport sink   (input valid, median, overflow, output ready);
endinterface

// ===== rtl/mots_ram.sv =====
`timescale 1ns / 1ps
// mots_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module mots_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/median_of_two_sorted_lists_core.sv =====
`timescale 1ns / 1ps
// median_of_two_sorted_lists_core: stores two equal-length ascending lists and
// finds the lower median of their union. Depends on mots_pkg, mots_if, mots_ram.
//
// Usage:
//   i_in carries one beat per index: a_value and b_value from the two lists at
//   the same position, last set on the final pair. Non-last beats are taken one
//   per cycle and give no result. Pairs beyond MAX_LEN are dropped and flagged.
//   After a last beat the block runs a halving search over the stored lists and
//   is not ready meanwhile. Each search step is one RAM read (one port per list)
//   and one signed compare, in states ST_RD and ST_CMP; a search takes at most
//   ceil(log2(n))+1 steps (n = pairs kept), fewer when the midpoints match early.
//   o_out gives one beat per list: the lower median and the overflow flag.
//   The result sits in an output register; loading of the next list may go on
//   while it waits. If the receiver stalls and a second search finishes, the
//   block holds that result and stays not ready until the first beat is taken.
//   Reset (synchronous, active low) clears the pair count, the overflow flag,
//   the sequencer and the output valid. The list RAMs are not cleared; only
//   entries written in the current list are ever read.
module median_of_two_sorted_lists_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mots_in_if.sink     i_in,
    mots_out_if.source  o_out
);
    import mots_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                r_ovf_res, n_ovf_res;
    logic [ADDR_W-1:0]   r_s1, n_s1, r_e1, n_e1, r_s2, n_s2, r_e2, n_e2;
    logic [DATA_W-1:0]   r_res, n_res;
    logic                r_o_valid, n_o_valid;
    logic [DATA_W-1:0]   r_o_median, n_o_median;
    logic                r_o_ovf, n_o_ovf;

    logic                accept;
    logic                wr_en;
    logic [ADDR_W:0]     sum1, sum2;
    logic [ADDR_W-1:0]   m1, m2;
    logic [DATA_W-1:0]   rd_a, rd_b;
    logic                even, cont, a_lt_b;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign wr_en      = accept && (r_count < CNT_W'(MAX_LEN));

    assign sum1 = {1'b0, r_s1} + {1'b0, r_e1};
    assign sum2 = {1'b0, r_s2} + {1'b0, r_e2};
    assign m1   = sum1[ADDR_W:1];
    assign m2   = sum2[ADDR_W:1];

    mots_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.a_value),
        .i_raddr (m1),
        .o_rdata (rd_a)
    );

    mots_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.b_value),
        .i_raddr (m2),
        .o_rdata (rd_b)
    );

    // range length is e-s+1; even when s and e differ in bit 0
    assign even   = r_s1[0] ^ r_e1[0];
    assign cont   = (r_s1 < r_e1) || (r_s2 < r_e2);
    assign a_lt_b = $signed(rd_a) < $signed(rd_b);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_ovf_res  = r_ovf_res;
        n_s1       = r_s1;
        n_e1       = r_e1;
        n_s2       = r_s2;
        n_e2       = r_e2;
        n_res      = r_res;
        n_o_valid  = r_o_valid && !o_out.ready;
        n_o_median = r_o_median;
        n_o_ovf    = r_o_ovf;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (wr_en) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_s1      = '0;
                        n_s2      = '0;
                        n_e1      = wr_en ? r_count[ADDR_W-1:0] : ADDR_W'(MAX_LEN - 1);
                        n_e2      = wr_en ? r_count[ADDR_W-1:0] : ADDR_W'(MAX_LEN - 1);
                        n_ovf_res = r_ovf || !wr_en;
                        n_count   = '0;
                        n_ovf     = 1'b0;
                        n_state   = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                priority if (rd_a == rd_b) begin
                    n_res   = rd_a;
                    n_state = ST_DONE;
                end else if (!cont) begin
                    n_res   = a_lt_b ? rd_a : rd_b;
                    n_state = ST_DONE;
                end else if (a_lt_b) begin
                    n_s1    = even ? m1 + ADDR_W'(1) : m1;
                    n_e2    = m2;
                    n_state = ST_RD;
                end else begin
                    n_e1    = m1;
                    n_s2    = even ? m2 + ADDR_W'(1) : m2;
                    n_state = ST_RD;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_median = r_res;
                    n_o_ovf    = r_ovf_res;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ovf_res  <= n_ovf_res;
        r_s1       <= n_s1;
        r_e1       <= n_e1;
        r_s2       <= n_s2;
        r_e2       <= n_e2;
        r_res      <= n_res;
        r_o_median <= n_o_median;
        r_o_ovf    <= n_o_ovf;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.median   = $signed(r_o_median);
    assign o_out.overflow = r_o_ovf;
endmodule
